/* rtl/aso_pkg.sv */
package aso_pkg;

  localparam int COORD_W = 6;
  localparam int DIM_W   = COORD_W + 1;
  localparam int ADDR_W  = 2 * COORD_W;
  localparam int ALPHA_W = 8;

  localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(1 << COORD_W);

  // Configuration register indexes.
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  // Scan passes.
  localparam logic [1:0] PASS_A = 2'd0;
  localparam logic [1:0] PASS_B = 2'd1;
  localparam logic [1:0] PASS_C = 2'd2;
  localparam logic [1:0] PASS_D = 2'd3;

  // Input item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic [COORD_W-1:0]        pixel_x;
    logic [COORD_W-1:0]        pixel_y;
    logic signed [ALPHA_W-1:0] alpha_value;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               found;
  } out_item_t;

  typedef struct packed {
    logic restart;
    logic wr_pixel;
    logic skip_line;
    logic inner_step;
    logic take_hit;
    logic emit_done;
  } aso_cmd_t;

  typedef struct packed {
    logic done;
    logic in_range;
    logic hit;
    logic out_free;
  } aso_sts_t;

endpackage

/* rtl/alpha_staircase_outline_scan.sv */
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_data   (in_item_t: kind, pixel_x, pixel_y, alpha_value)
// out       out_valid / out_ready  out_data  (out_item_t: point_x, point_y, found)
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (threshold, width, height)
//
// A load item writes the image memory and restarts the scan. A fetch is accepted, then skips
// each line out of range and tests pixels in turn, using the registered image memory read.
// Reset restores the registers and the scan position; image contents are undefined until loaded.
// No new item is taken while a fetch is in progress; a result waits in the output register.
module alpha_staircase_outline_scan
  import aso_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  aso_cmd_t cmd;
  aso_sts_t sts;

  assign cfg_ready = 1'b1;

  aso_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  aso_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/aso_ctrl.sv */
module aso_ctrl
  import aso_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_kind,
  output logic     in_ready,
  input  aso_sts_t sts,
  output aso_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_STEP  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       in_fire;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_kind == KIND_LOAD) begin
            cmd.wr_pixel = 1'b1;
            cmd.restart  = 1'b1;
          end else begin
            state_next = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (sts.done) begin
          if (sts.out_free) begin
            cmd.emit_done = 1'b1;
            state_next    = S_IDLE;
          end
        end else if (!sts.in_range) begin
          cmd.skip_line = 1'b1;
        end else begin
          // The pixel under the scan position is being read this cycle.
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.hit) begin
          if (sts.out_free) begin
            cmd.take_hit = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.inner_step = 1'b1;
          state_next     = S_STEP;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_check_after_step: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> $past(state) == S_STEP || $past(state) == S_CHECK)
    else $error("check state entered without a preceding read");

  a_result_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.take_hit || cmd.emit_done) |-> sts.out_free)
    else $error("result loaded while the output register is occupied");

  a_skip_only_out_of_range: assert property (@(posedge clk) disable iff (rst)
    cmd.skip_line |-> !sts.in_range && !sts.done)
    else $error("line skipped while still in range");

  a_fetch_starts_scan: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_kind == KIND_FETCH |=> state == S_STEP)
    else $error("fetch item did not start the scan");
`endif

endmodule

/* rtl/aso_dpath.sv */
module aso_dpath
  import aso_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    in_data,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  aso_cmd_t    cmd,
  output aso_sts_t    sts,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  logic signed [ALPHA_W-1:0] mem [0:(1 << ADDR_W)-1];
  logic signed [ALPHA_W-1:0] rd_data;

  logic signed [ALPHA_W-1:0] threshold;
  logic [DIM_W-1:0]          active_width;
  logic [DIM_W-1:0]          active_height;

  logic [1:0]       scan_pass;
  logic [DIM_W-1:0] outer_index;
  logic [DIM_W-1:0] inner_index;
  logic [DIM_W-1:0] scan_bound;
  logic             scan_done;

  logic [DIM_W-1:0]   w_eff, h_eff, h_restart;
  logic [COORD_W-1:0] px, py;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic               cfg_write, restart;
  logic               line_ok;
  logic [DIM_W-1:0]   nl_outer, nl_inner;
  logic [1:0]         pass_nx;
  logic [DIM_W-1:0]   sp_outer, sp_inner, sp_bound;
  logic [DIM_W-1:0]   outer_inc, outer_dec;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > MAX_DIM) begin
      r = MAX_DIM;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign w_eff     = sat_dim(active_width);
  assign h_eff     = sat_dim(active_height);
  assign cfg_write = cfg_valid && (cfg_index == REG_THRESHOLD || cfg_index == REG_WIDTH ||
                                   cfg_index == REG_HEIGHT);
  assign restart   = cmd.restart || cfg_write;
  // A height written in this very cycle already sets the start of scan a.
  assign h_restart = (cfg_valid && cfg_index == REG_HEIGHT) ?
                     sat_dim(cfg_data[DIM_W-1:0]) : h_eff;

  // Scans a and c walk along columns; b and d walk along rows.
  always_comb begin
    if (scan_pass == PASS_A || scan_pass == PASS_C) begin
      px = outer_index[COORD_W-1:0];
      py = inner_index[COORD_W-1:0];
    end else begin
      px = inner_index[COORD_W-1:0];
      py = outer_index[COORD_W-1:0];
    end
  end

  assign rd_addr = {py, px};
  assign wr_addr = {in_data.pixel_y, in_data.pixel_x};

  always_ff @(posedge clk) begin
    if (cmd.wr_pixel) begin
      mem[wr_addr] <= in_data.alpha_value;
    end
    rd_data <= mem[rd_addr];
  end

  assign outer_inc = outer_index + DIM_W'(1);
  assign outer_dec = outer_index - DIM_W'(1);
  assign pass_nx   = scan_pass + 2'd1;

  always_comb begin
    case (scan_pass)
      PASS_A: begin
        line_ok  = outer_inc < w_eff;
        nl_outer = outer_inc;
        nl_inner = h_eff - DIM_W'(1);
      end
      PASS_B: begin
        line_ok  = outer_index != '0;
        nl_outer = outer_dec;
        nl_inner = w_eff - DIM_W'(1);
      end
      PASS_C: begin
        line_ok  = outer_index != '0;
        nl_outer = outer_dec;
        nl_inner = '0;
      end
      default: begin
        line_ok  = outer_inc < h_eff;
        nl_outer = outer_inc;
        nl_inner = '0;
      end
    endcase
  end

  always_comb begin
    case (pass_nx)
      PASS_A: begin
        sp_outer = '0;
        sp_inner = h_eff - DIM_W'(1);
        sp_bound = '0;
      end
      PASS_B: begin
        sp_outer = h_eff - DIM_W'(1);
        sp_inner = w_eff - DIM_W'(1);
        sp_bound = '0;
      end
      PASS_C: begin
        sp_outer = w_eff - DIM_W'(1);
        sp_inner = '0;
        sp_bound = h_eff - DIM_W'(1);
      end
      default: begin
        sp_outer = '0;
        sp_inner = '0;
        sp_bound = w_eff;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= ALPHA_W'(1);
      active_width  <= MAX_DIM;
      active_height <= MAX_DIM;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD: threshold     <= cfg_data;
        REG_WIDTH:     active_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:    active_height <= cfg_data[DIM_W-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pass   <= PASS_A;
      outer_index <= '0;
      inner_index <= MAX_DIM - DIM_W'(1);
      scan_bound  <= '0;
      scan_done   <= 1'b0;
    end else if (restart) begin
      scan_pass   <= PASS_A;
      outer_index <= '0;
      inner_index <= h_restart - DIM_W'(1);
      scan_bound  <= '0;
      scan_done   <= 1'b0;
    end else if (cmd.skip_line || cmd.take_hit) begin
      if (line_ok) begin
        outer_index <= nl_outer;
        inner_index <= nl_inner;
        if (cmd.take_hit) begin
          scan_bound <= inner_index;
        end
      end else if (scan_pass == PASS_D) begin
        scan_done <= 1'b1;
        if (cmd.take_hit) begin
          scan_bound <= inner_index;
        end
      end else begin
        scan_pass   <= pass_nx;
        outer_index <= sp_outer;
        inner_index <= sp_inner;
        scan_bound  <= sp_bound;
      end
    end else if (cmd.inner_step) begin
      if (scan_pass == PASS_A || scan_pass == PASS_B) begin
        inner_index <= inner_index - DIM_W'(1);
      end else begin
        inner_index <= inner_index + DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.take_hit || cmd.emit_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      out_data.point_x <= px;
      out_data.point_y <= py;
      out_data.found   <= 1'b1;
    end else if (cmd.emit_done) begin
      out_data <= '0;
    end
  end

  always_comb begin
    sts.done     = scan_done;
    sts.in_range = (scan_pass == PASS_A || scan_pass == PASS_B) ?
                   (inner_index > scan_bound) : (inner_index < scan_bound);
    sts.hit      = rd_data >= threshold;
    sts.out_free = !out_valid || out_ready;
  end

endmodule
